@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define QA_NEVER(lbl, expr, msg) \
	`QA_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/qalu_pkg.sv @@
package qalu_pkg;

	localparam int DW = 32;
	localparam int LW = 2 * DW + 1;
	localparam int RB = DW + 1;

	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [3:0] {
		CMD_ADD    = 4'd0,
		CMD_SUB    = 4'd1,
		CMD_NEG    = 4'd2,
		CMD_CONJ   = 4'd3,
		CMD_MUL    = 4'd4,
		CMD_SQUARE = 4'd5,
		CMD_SCALE  = 4'd6,
		CMD_DIVIDE = 4'd7,
		CMD_LEN2   = 4'd8,
		CMD_LEN    = 4'd9,
		CMD_NORM   = 4'd10,
		CMD_INV    = 4'd11,
		CMD_EQUAL  = 4'd12
	} cmd_t;

	typedef struct packed {
		logic [3:0]           cmd;
		logic signed [DW-1:0] a_w;
		logic signed [DW-1:0] a_x;
		logic signed [DW-1:0] a_y;
		logic signed [DW-1:0] a_z;
		logic signed [DW-1:0] b_w;
		logic signed [DW-1:0] b_x;
		logic signed [DW-1:0] b_y;
		logic signed [DW-1:0] b_z;
		logic signed [DW-1:0] scalar_k;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] r_w;
		logic signed [DW-1:0] r_x;
		logic signed [DW-1:0] r_y;
		logic signed [DW-1:0] r_z;
		logic [DW-2:0]        r_scalar;
		logic                 is_equal;
		logic                 overflow;
		logic                 div_error;
	} rsp_t;

	typedef struct packed {
		logic [3:0]          cmd;
		logic [3:0][DW-1:0]  res;
		logic [DW-2:0]       scal;
		logic                ov;
		logic                eq;
		logic [3:0][DW-1:0]  a;
		logic [DW-1:0]       k;
		logic [LW-1:0]       l2;
		logic [RB-1:0]       root;
	} side_t;

	typedef struct packed {
		logic [3:0][DW-1:0] mag;
		logic [3:0]         neg;
		logic [3:0]         sat;
		logic               err;
	} quot_t;

endpackage

@@ rtl/quaternion_alu_core.sv @@
// Channel  | Handshake            | Word
// request  | req_valid, req_ready | req (req_t): opcode, quaternions a and b, scalar k
// response | rsp_valid, rsp_ready | rsp (rsp_t): quaternion, scalar, three flags
//
// One word is accepted per cycle unless the pipeline is held; its response passes
// through 70 register stages: three multiply and add stages, 33 square root stages,
// 33 divider stages (set-up plus one quotient bit each) and the output stage.
// Reset clears every stage valid bit; there is no start-up sweep.
// A held response freezes the whole pipeline and req_ready falls with it.
`include "assert_macros.svh"

module quaternion_alu_core import qalu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic               en;
	logic               f_vld, s_vld, d_vld;
	side_t              f_side, s_side, d_side;
	quot_t              d_quot;
	rsp_t               nx;
	logic [3:0][DW-1:0] rv;
	logic [3:0]         lov;
	logic [DW-1:0]      m;
	rsp_t               rsp_q;
	logic               vld_q;

	assign en        = !vld_q || rsp_ready;
	assign req_ready = en;

	qalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (req_valid),
		.in_data  (req),
		.out_vld  (f_vld),
		.out_side (f_side)
	);

	qalu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.in_side  (f_side),
		.out_vld  (s_vld),
		.out_side (s_side)
	);

	qalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_vld),
		.in_side  (s_side),
		.out_vld  (d_vld),
		.out_side (d_side),
		.out_quot (d_quot)
	);

	always_comb begin
		nx = '0;
		for (int j = 0; j < 4; j++) begin
			m      = d_quot.mag[j];
			lov[j] = 1'b0;
			if (d_quot.sat[j]) begin
				lov[j] = 1'b1;
				rv[j]  = d_quot.neg[j] ? SMIN : SMAX;
			end else if (d_quot.neg[j]) begin
				if (m > SMIN) begin
					lov[j] = 1'b1;
					rv[j]  = SMIN;
				end else begin
					rv[j] = ~m + 1'b1;
				end
			end else if (m[DW-1]) begin
				lov[j] = 1'b1;
				rv[j]  = SMAX;
			end else begin
				rv[j] = m;
			end
		end
		if (d_side.cmd == CMD_DIVIDE || d_side.cmd == CMD_NORM || d_side.cmd == CMD_INV) begin
			if (d_quot.err) begin
				nx.div_error = 1'b1;
			end else begin
				nx.r_w      = rv[0];
				nx.r_x      = rv[1];
				nx.r_y      = rv[2];
				nx.r_z      = rv[3];
				nx.overflow = |lov;
			end
		end else if (d_side.cmd == CMD_LEN) begin
			if (d_side.root[RB-1:DW-1] != '0) begin
				nx.r_scalar = '1;
				nx.overflow = 1'b1;
			end else begin
				nx.r_scalar = d_side.root[DW-2:0];
			end
		end else begin
			nx.r_w      = d_side.res[0];
			nx.r_x      = d_side.res[1];
			nx.r_y      = d_side.res[2];
			nx.r_z      = d_side.res[3];
			nx.r_scalar = d_side.scal;
			nx.is_equal = d_side.eq;
			nx.overflow = d_side.ov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= nx;
		end
	end

	assign rsp_valid = vld_q;
	assign rsp       = rsp_q;

	`QA_NEVER(a_err_no_ov, rsp_valid && rsp.div_error && rsp.overflow, "error word also flags overflow")
	`QA_NEVER(a_err_scal, rsp_valid && rsp.div_error && rsp.r_scalar != '0, "error word has a scalar")
	`QA_ASSERT(a_eq_clean, rsp_valid && rsp.is_equal |-> rsp.r_w == '0 && rsp.r_z == '0 && !rsp.overflow, "equal word not clean")
	`QA_ASSERT(a_stall, rsp_valid && !rsp_ready |-> !req_ready, "request taken while pipeline held")

endmodule

@@ rtl/qalu_front.sv @@
module qalu_front import qalu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  req_t  in_data,
	output logic  out_vld,
	output side_t out_side
);

	localparam int PW = 2 * DW;
	localparam int SW = 2 * DW + 2;

	// Hamilton product term order: operand index of p and q, and negated terms.
	localparam logic [1:0] HX [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}};
	localparam logic [1:0] HY [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd2, 2'd1}};
	localparam logic [3:0] HN [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

	function automatic logic [DW:0] sat_s(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = $signed({{(SW-DW){1'b0}}, SMAX});
		lo = $signed({{(SW-DW){1'b1}}, SMIN});
		if (v > hi) begin
			sat_s = {1'b1, SMAX};
		end else if (v < lo) begin
			sat_s = {1'b1, SMIN};
		end else begin
			sat_s = {1'b0, v[DW-1:0]};
		end
	endfunction

	logic [3:0][DW-1:0]    a, b, q;
	logic signed [DW-1:0]  x [4][4];
	logic signed [DW-1:0]  y [4][4];
	logic [3:0]            ng [4];
	logic signed [DW:0]    lin [4];
	logic                  eq;

	logic signed [PW-1:0]  m_s1 [4][4];
	logic [3:0]            ng_s1 [4];
	logic signed [DW:0]    lin_s1 [4];
	logic [3:0]            cmd_s1;
	logic                  eq_s1;
	logic [3:0][DW-1:0]    a_s1;
	logic [DW-1:0]         k_s1;
	logic                  vld_s1;

	logic signed [SW-1:0]  e [4][4];
	logic signed [SW-1:0]  h0_s2 [4];
	logic signed [SW-1:0]  h1_s2 [4];
	logic signed [DW:0]    lin_s2 [4];
	logic [3:0]            cmd_s2;
	logic                  eq_s2;
	logic [3:0][DW-1:0]    a_s2;
	logic [DW-1:0]         k_s2;
	logic                  vld_s2;

	logic signed [SW-1:0]  sum [4];
	logic signed [SW-1:0]  val [4];
	logic [DW:0]           st [4];
	logic [SW-1:0]         u;
	side_t                 nx;
	side_t                 side_s3;
	logic                  vld_s3;

	assign a = {in_data.a_z, in_data.a_y, in_data.a_x, in_data.a_w};
	assign b = {in_data.b_z, in_data.b_y, in_data.b_x, in_data.b_w};

	always_comb begin
		q  = (in_data.cmd == CMD_MUL) ? b : a;
		eq = (in_data.cmd == CMD_EQUAL) && (a == b);
		for (int j = 0; j < 4; j++) begin
			ng[j] = '0;
			for (int t = 0; t < 4; t++) begin
				x[j][t] = '0;
				y[j][t] = '0;
			end
		end
		if (in_data.cmd == CMD_MUL || in_data.cmd == CMD_SQUARE) begin
			for (int j = 0; j < 4; j++) begin
				ng[j] = HN[j];
				for (int t = 0; t < 4; t++) begin
					x[j][t] = a[HX[j][t]];
					y[j][t] = q[HY[j][t]];
				end
			end
		end else if (in_data.cmd == CMD_SCALE) begin
			for (int j = 0; j < 4; j++) begin
				x[j][0] = a[j];
				y[j][0] = in_data.scalar_k;
			end
		end else if (in_data.cmd == CMD_LEN2 || in_data.cmd == CMD_LEN ||
				in_data.cmd == CMD_NORM || in_data.cmd == CMD_INV) begin
			for (int t = 0; t < 4; t++) begin
				x[0][t] = a[t];
				y[0][t] = a[t];
			end
		end
		for (int j = 0; j < 4; j++) begin
			lin[j] = '0;
			if (in_data.cmd == CMD_ADD) begin
				lin[j] = $signed({a[j][DW-1], a[j]}) + $signed({b[j][DW-1], b[j]});
			end else if (in_data.cmd == CMD_SUB) begin
				lin[j] = $signed({a[j][DW-1], a[j]}) - $signed({b[j][DW-1], b[j]});
			end else if (in_data.cmd == CMD_NEG || (in_data.cmd == CMD_CONJ && j != 0)) begin
				lin[j] = -$signed({a[j][DW-1], a[j]});
			end else if (in_data.cmd == CMD_CONJ) begin
				lin[j] = $signed({a[j][DW-1], a[j]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			for (int t = 0; t < 4; t++) begin
				e[j][t] = ng_s1[j][t] ? -SW'(m_s1[j][t]) : SW'(m_s1[j][t]);
			end
		end
	end

	always_comb begin
		nx      = '0;
		nx.cmd  = cmd_s2;
		nx.eq   = eq_s2;
		nx.a    = a_s2;
		nx.k    = k_s2;
		for (int j = 0; j < 4; j++) begin
			sum[j] = h0_s2[j] + h1_s2[j];
			if (cmd_s2 == CMD_MUL || cmd_s2 == CMD_SQUARE || cmd_s2 == CMD_SCALE) begin
				val[j] = sum[j] >>> FRAC_BITS;
			end else if (cmd_s2 == CMD_ADD || cmd_s2 == CMD_SUB ||
					cmd_s2 == CMD_NEG || cmd_s2 == CMD_CONJ) begin
				val[j] = SW'(lin_s2[j]);
			end else begin
				val[j] = '0;
			end
			st[j]      = sat_s(val[j]);
			nx.res[j]  = st[j][DW-1:0];
			nx.ov      = nx.ov | st[j][DW];
		end
		u = sum[0] >> FRAC_BITS;
		if (cmd_s2 == CMD_LEN2) begin
			if (u[SW-1:DW-1] != '0) begin
				nx.scal = '1;
				nx.ov   = 1'b1;
			end else begin
				nx.scal = u[DW-2:0];
			end
		end
		nx.l2 = sum[0][LW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				ng_s1[j]  <= ng[j];
				lin_s1[j] <= lin[j];
				for (int t = 0; t < 4; t++) begin
					m_s1[j][t] <= x[j][t] * y[j][t];
				end
				h0_s2[j]  <= e[j][0] + e[j][1];
				h1_s2[j]  <= e[j][2] + e[j][3];
				lin_s2[j] <= lin_s1[j];
			end
			cmd_s1  <= in_data.cmd;
			eq_s1   <= eq;
			a_s1    <= a;
			k_s1    <= in_data.scalar_k;
			cmd_s2  <= cmd_s1;
			eq_s2   <= eq_s1;
			a_s2    <= a_s1;
			k_s2    <= k_s1;
			side_s3 <= nx;
		end
	end

	assign out_vld  = vld_s3;
	assign out_side = side_s3;

endmodule

@@ rtl/qalu_sqrt.sv @@
module qalu_sqrt import qalu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  side_t in_side,
	output logic  out_vld,
	output side_t out_side
);

	localparam int VW = 2 * RB;
	localparam int RW = RB + 2;

	logic          vld_s  [RB];
	side_t         side_s [RB];
	logic [RW-1:0] rem_s  [RB];
	logic [RB-1:0] root_s [RB];
	logic [VW-1:0] val_s  [RB];

	logic          vin  [RB];
	side_t         sin  [RB];
	logic [RW-1:0] rin  [RB];
	logic [RB-1:0] qin  [RB];
	logic [VW-1:0] din  [RB];
	logic [RW-1:0] r2   [RB];
	logic [RW-1:0] t    [RB];
	logic          ge   [RB];

	// One root bit per stage, two radicand bits consumed from the top.
	always_comb begin
		for (int i = 0; i < RB; i++) begin
			if (i == 0) begin
				vin[i] = in_vld;
				sin[i] = in_side;
				rin[i] = '0;
				qin[i] = '0;
				din[i] = VW'(in_side.l2);
			end else begin
				vin[i] = vld_s[i-1];
				sin[i] = side_s[i-1];
				rin[i] = rem_s[i-1];
				qin[i] = root_s[i-1];
				din[i] = val_s[i-1];
			end
			r2[i] = {rin[i][RB-1:0], din[i][VW-1-2*i -: 2]};
			t[i]  = {qin[i], 2'b01};
			ge[i] = r2[i] >= t[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RB; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			for (int i = 0; i < RB; i++) begin
				vld_s[i] <= vin[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < RB; i++) begin
				side_s[i] <= sin[i];
				rem_s[i]  <= ge[i] ? (r2[i] - t[i]) : r2[i];
				root_s[i] <= {qin[i][RB-2:0], ge[i]};
				val_s[i]  <= din[i];
			end
		end
	end

	always_comb begin
		out_side      = side_s[RB-1];
		out_side.root = root_s[RB-1];
	end

	assign out_vld = vld_s[RB-1];

endmodule

@@ rtl/qalu_div.sv @@
module qalu_div import qalu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  side_t in_side,
	output logic  out_vld,
	output side_t out_side,
	output quot_t out_quot
);

	localparam int NUMW = DW + 2 * FRAC_BITS;
	localparam int DEXW = LW + DW;
	localparam int CW   = (NUMW > DEXW) ? NUMW : DEXW;
	localparam int DS   = DW + 1;

	logic               vld_s  [DS];
	side_t              side_s [DS];
	logic [LW-1:0]      den_s  [DS];
	quot_t              q_s    [DS];
	logic [3:0][LW-1:0] rem_s  [DS];

	logic [DW-1:0]      mag [4];
	logic [DW-1:0]      kmag;
	logic [CW-1:0]      num [4];
	logic [CW-1:0]      shd [4];
	logic [CW-1:0]      dext;
	logic [LW-1:0]      p_den;
	quot_t              p_q;
	logic [3:0][LW-1:0] p_rem;

	quot_t              st_q   [DS];
	logic [3:0][LW-1:0] st_rem [DS];

	// Operand set-up and the range check that flags quotients too large for a word.
	always_comb begin
		kmag  = in_side.k[DW-1] ? (~in_side.k + 1'b1) : in_side.k;
		p_q   = '0;
		p_den = '0;
		if (in_side.cmd == CMD_DIVIDE) begin
			p_den = LW'(kmag);
			p_q.err = (in_side.k == '0);
		end else if (in_side.cmd == CMD_NORM) begin
			p_den = LW'(in_side.root);
			p_q.err = (in_side.root == '0);
		end else if (in_side.cmd == CMD_INV) begin
			p_den = in_side.l2;
			p_q.err = (in_side.l2 == '0);
		end
		dext = CW'({p_den, {DW{1'b0}}});
		for (int j = 0; j < 4; j++) begin
			mag[j] = in_side.a[j][DW-1] ? (~in_side.a[j] + 1'b1) : in_side.a[j];
			if (in_side.cmd == CMD_INV) begin
				num[j] = CW'(mag[j]) << (2 * FRAC_BITS);
				p_q.neg[j] = in_side.a[j][DW-1] ^ (j != 0);
			end else begin
				num[j] = CW'(mag[j]) << FRAC_BITS;
				p_q.neg[j] = in_side.a[j][DW-1] ^
					((in_side.cmd == CMD_DIVIDE) && in_side.k[DW-1]);
			end
			p_q.sat[j] = num[j] >= dext;
			shd[j]     = num[j] >> DW;
			p_rem[j]   = shd[j][LW-1:0];
			p_q.mag[j] = num[j][DW-1:0];
		end
	end

	// Restoring division, one quotient bit per stage in each of the four lanes.
	always_comb begin
		logic [LW:0] r2;
		logic [LW:0] df;
		logic        ge;
		st_q[0]   = '0;
		st_rem[0] = '0;
		for (int i = 1; i < DS; i++) begin
			st_q[i] = q_s[i-1];
			for (int j = 0; j < 4; j++) begin
				r2 = {rem_s[i-1][j], q_s[i-1].mag[j][DW-1]};
				df = r2 - {1'b0, den_s[i-1]};
				ge = r2 >= {1'b0, den_s[i-1]};
				st_rem[i][j]    = ge ? df[LW-1:0] : r2[LW-1:0];
				st_q[i].mag[j]  = {q_s[i-1].mag[j][DW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < DS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			den_s[0]  <= p_den;
			q_s[0]    <= p_q;
			rem_s[0]  <= p_rem;
			for (int i = 1; i < DS; i++) begin
				side_s[i] <= side_s[i-1];
				den_s[i]  <= den_s[i-1];
				q_s[i]    <= st_q[i];
				rem_s[i]  <= st_rem[i];
			end
		end
	end

	assign out_vld  = vld_s[DS-1];
	assign out_side = side_s[DS-1];
	assign out_quot = q_s[DS-1];

endmodule
